[rtl/srpc_pkg.sv]
package srpc_pkg;

   localparam int OBS_W        = 6;
   localparam int MARGIN_W     = 9;
   localparam int CNT_W        = 17;
   localparam int PERIOD_W     = 22;
   localparam int FRAC_BITS    = 16;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 9;
   localparam int PERMILLE_DIV = 1000;

   localparam logic [OBS_W-1:0]    OBS_RESET    = OBS_W'(10);
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(100);

   localparam logic [CSR_INDEX_W-1:0] CSR_OBSERVE_SECONDS = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MARGIN_PERMILLE = CSR_INDEX_W'(1);

   typedef struct packed {
      logic no_crossings;
      logic store_overflow;
   } rsp_flags_type;

endpackage

[rtl/srpc_ram.sv]
module srpc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/srpc_div.sv]
module srpc_div #(
   parameter int DVD_W = 25,
   parameter int DVS_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CW = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   rem_sh;
   logic [DVS_W:0]   diff;
   logic             ge;

   assign rem_sh = {rem_ff, quo_ff[DVD_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign ge     = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DVD_W);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/signal_range_period_calibrator.sv]
// Loads one record of signed samples at one per cycle into a sample RAM while tracking its
// minimum and maximum; samples past MAX_SAMPLES are dropped and flagged. After the sample
// with tlast, input stalls while the block derives the two hysteresis thresholds (the
// divisions by 1000 are reciprocal multiplications), walks the stored record one sample
// per cycle through the RAM read port counting rising crossings, and divides the window
// by the count. When a crossing was found, the serial period divider does this division,
// one quotient bit per cycle; with none the period is zero. The result moves into an
// output register and loading of the next record resumes; if the previous result still
// waits there, the block holds until it is taken.
module signal_range_period_calibrator
   import srpc_pkg::*;
#(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   req_tvalid,
   output logic                                                   req_tready,
   // sample
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]                       req_tdata,
   input  logic                                                   req_tlast,
   output logic                                                   rsp_tvalid,
   input  logic                                                   rsp_tready,
   // min_level, max_level, low_threshold, high_threshold, crossing_count, period_q16
   output logic [((4*SAMPLE_BITS+CNT_W+PERIOD_W+7)/8)*8-1:0]      rsp_tdata,
   // no_crossings, store_overflow
   output logic [1:0]                                             rsp_tuser,
   input  logic                                                   csr_valid,
   output logic                                                   csr_ready,
   input  logic [CSR_INDEX_W-1:0]                                 csr_index,
   input  logic [CSR_DATA_W-1:0]                                  csr_data
);

   localparam int SB      = SAMPLE_BITS;
   localparam int ADDR_W  = $clog2(MAX_SAMPLES);
   localparam int SCNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int OUT_RAW = 4 * SB + CNT_W + PERIOD_W;
   localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
   localparam int PROD_W  = SB + MARGIN_W;
   localparam int DVD_W   = PERIOD_W;
   localparam int THR_W   = SB + 2;
   localparam int RCP_SH  = PROD_W + 10;
   localparam int RCP_W   = PROD_W + 1;
   localparam int RCP_PW  = PROD_W + RCP_W;

   localparam logic [63:0] RCP_FULL =
      ((64'd1 << RCP_SH) + 64'(PERMILLE_DIV - 1)) / 64'(PERMILLE_DIV);
   localparam logic [RCP_W-1:0] PERMILLE_RCP = RCP_FULL[RCP_W-1:0];

   localparam logic signed [SB-1:0] SMP_MAXV = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SMP_MINV = {1'b1, {(SB-1){1'b0}}};

   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_MUL    = 3'd1;
   localparam logic [2:0] ST_DIV_LO = 3'd2;
   localparam logic [2:0] ST_DIV_HI = 3'd3;
   localparam logic [2:0] ST_THR    = 3'd4;
   localparam logic [2:0] ST_WALK   = 3'd5;
   localparam logic [2:0] ST_DIV_P  = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic [OBS_W-1:0]        obs_ff, obs_in;
   logic [MARGIN_W-1:0]     margin_ff, margin_in;
   logic [SCNT_W-1:0]       smp_count_ff, smp_count_in;
   logic signed [SB-1:0]    min_ff, min_in;
   logic signed [SB-1:0]    max_ff, max_in;
   logic                    ovf_ff, ovf_in;
   logic [PROD_W-1:0]       prod_lo_ff, prod_lo_in;
   logic [PROD_W-1:0]       prod_hi_ff, prod_hi_in;
   logic [SB-1:0]           margin_lo_ff, margin_lo_in;
   logic [SB-1:0]           margin_hi_ff, margin_hi_in;
   logic signed [SB-1:0]    low_ff, low_in;
   logic signed [SB-1:0]    high_ff, high_in;
   logic [SCNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic                    first_ff, first_in;
   logic                    up_ff, up_in;
   logic [CNT_W-1:0]        cross_ff, cross_in;
   logic [PERIOD_W-1:0]     period_ff, period_in;
   logic                    div_launch_ff, div_launch_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic signed [SB-1:0]    rsp_min_ff, rsp_min_in;
   logic signed [SB-1:0]    rsp_max_ff, rsp_max_in;
   logic signed [SB-1:0]    rsp_low_ff, rsp_low_in;
   logic signed [SB-1:0]    rsp_high_ff, rsp_high_in;
   logic [CNT_W-1:0]        rsp_cross_ff, rsp_cross_in;
   logic [PERIOD_W-1:0]     rsp_period_ff, rsp_period_in;
   rsp_flags_type           rsp_flags_ff, rsp_flags_in;

   logic                    accept;
   logic                    store_full;
   logic signed [SB-1:0]    smp;
   logic [SB-1:0]           abs_lo;
   logic [SB-1:0]           abs_hi;
   logic signed [THR_W-1:0] low_w;
   logic signed [THR_W-1:0] high_w;
   logic                    rd_issue;
   logic [SB-1:0]           ram_q;
   logic signed [SB-1:0]    rv;
   logic                    up_eff;
   logic                    rsp_load;
   logic [PROD_W-1:0]       rcp_src;
   logic [RCP_PW-1:0]       rcp_prod;
   logic [SB-1:0]           rcp_quo;
   logic                    div_done;
   logic [DVD_W-1:0]        div_quo;
   logic [DVD_W-1:0]        div_dividend;
   logic [CNT_W-1:0]        div_divisor;

   function automatic logic signed [SB-1:0] sat(input logic signed [THR_W-1:0] v);
      logic fits;
      fits = (v[THR_W-1:SB-1] == '0) || (v[THR_W-1:SB-1] == '1);
      if (fits) begin
         return v[SB-1:0];
      end else if (v[THR_W-1]) begin
         return SMP_MINV;
      end else begin
         return SMP_MAXV;
      end
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign store_full = smp_count_ff == SCNT_W'(MAX_SAMPLES);
   assign smp        = req_tdata[SB-1:0];
   assign abs_lo     = min_ff[SB-1] ? (~min_ff + SB'(1)) : min_ff;
   assign abs_hi     = max_ff[SB-1] ? (~max_ff + SB'(1)) : max_ff;
   assign low_w      = THR_W'(min_ff) + $signed({2'b00, margin_lo_ff});
   assign high_w     = THR_W'(max_ff) - $signed({2'b00, margin_hi_ff});
   assign rd_issue   = (state_ff == ST_WALK) && (rd_idx_ff < smp_count_ff);
   assign rv         = ram_q;
   assign up_eff     = first_ff ? (rv > high_ff) : up_ff;
   assign rsp_load   = (state_ff == ST_OUT) && (!rsp_tvalid_ff || rsp_tready);

   // floor(x / 1000) as (x * ceil(2^RCP_SH / 1000)) >> RCP_SH, exact for x below 2^PROD_W
   assign rcp_src  = (state_ff == ST_DIV_HI) ? prod_hi_ff : prod_lo_ff;
   assign rcp_prod = RCP_PW'(rcp_src) * RCP_PW'(PERMILLE_RCP);
   assign rcp_quo  = rcp_prod[RCP_SH +: SB];

   assign div_dividend = DVD_W'({obs_ff, {FRAC_BITS{1'b0}}});
   assign div_divisor  = cross_ff;

   srpc_ram #(
      .WIDTH(SB),
      .DEPTH(MAX_SAMPLES)
   ) u_store (
      .clock  (clock),
      .wr_en  (accept && !store_full),
      .wr_addr(smp_count_ff[ADDR_W-1:0]),
      .wr_data(smp),
      .rd_en  (rd_issue),
      .rd_addr(rd_idx_ff[ADDR_W-1:0]),
      .rd_data(ram_q)
   );

   srpc_div #(
      .DVD_W(DVD_W),
      .DVS_W(CNT_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_launch_ff),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quo)
   );

   always_comb begin
      state_in      = state_ff;
      obs_in        = obs_ff;
      margin_in     = margin_ff;
      smp_count_in  = smp_count_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      ovf_in        = ovf_ff;
      prod_lo_in    = prod_lo_ff;
      prod_hi_in    = prod_hi_ff;
      margin_lo_in  = margin_lo_ff;
      margin_hi_in  = margin_hi_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      rd_idx_in     = rd_idx_ff;
      rd_valid_in   = rd_issue;
      first_in      = first_ff;
      up_in         = up_ff;
      cross_in      = cross_ff;
      period_in     = period_ff;
      div_launch_in = 1'b0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_low_in    = rsp_low_ff;
      rsp_high_in   = rsp_high_ff;
      rsp_cross_in  = rsp_cross_ff;
      rsp_period_in = rsp_period_ff;
      rsp_flags_in  = rsp_flags_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OBSERVE_SECONDS: obs_in    = csr_data[OBS_W-1:0];
            CSR_MARGIN_PERMILLE: margin_in = csr_data[MARGIN_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (store_full) begin
                  ovf_in = 1'b1;
               end else begin
                  smp_count_in = smp_count_ff + SCNT_W'(1);
               end
               if (smp < min_ff) begin
                  min_in = smp;
               end
               if (smp > max_ff) begin
                  max_in = smp;
               end
               if (req_tlast) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_lo_in = PROD_W'(abs_lo) * PROD_W'(margin_ff);
            prod_hi_in = PROD_W'(abs_hi) * PROD_W'(margin_ff);
            state_in   = ST_DIV_LO;
         end
         ST_DIV_LO: begin
            margin_lo_in = rcp_quo;
            state_in     = ST_DIV_HI;
         end
         ST_DIV_HI: begin
            margin_hi_in = rcp_quo;
            state_in     = ST_THR;
         end
         ST_THR: begin
            low_in    = sat(low_w);
            high_in   = sat(high_w);
            rd_idx_in = '0;
            first_in  = 1'b1;
            up_in     = 1'b0;
            cross_in  = '0;
            state_in  = ST_WALK;
         end
         ST_WALK: begin
            if (rd_issue) begin
               rd_idx_in = rd_idx_ff + SCNT_W'(1);
            end
            if (rd_valid_ff) begin
               first_in = 1'b0;
               if (!up_eff && rv > high_ff) begin
                  cross_in = cross_ff + CNT_W'(1);
                  up_in    = 1'b1;
               end else if (up_eff && rv < low_ff) begin
                  up_in = 1'b0;
               end else begin
                  up_in = up_eff;
               end
            end else if (!rd_issue) begin
               if (cross_ff == '0) begin
                  period_in = '0;
                  state_in  = ST_OUT;
               end else begin
                  div_launch_in = 1'b1;
                  state_in      = ST_DIV_P;
               end
            end
         end
         ST_DIV_P: begin
            if (div_done) begin
               period_in = div_quo[PERIOD_W-1:0];
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_tvalid_in               = 1'b1;
               rsp_min_in                  = min_ff;
               rsp_max_in                  = max_ff;
               rsp_low_in                  = low_ff;
               rsp_high_in                 = high_ff;
               rsp_cross_in                = cross_ff;
               rsp_period_in               = period_ff;
               rsp_flags_in.no_crossings   = cross_ff == '0;
               rsp_flags_in.store_overflow = ovf_ff;
               smp_count_in                = '0;
               min_in                      = SMP_MAXV;
               max_in                      = SMP_MINV;
               ovf_in                      = 1'b0;
               state_in                    = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         obs_ff        <= OBS_RESET;
         margin_ff     <= MARGIN_RESET;
         smp_count_ff  <= '0;
         min_ff        <= SMP_MAXV;
         max_ff        <= SMP_MINV;
         ovf_ff        <= 1'b0;
         rd_valid_ff   <= 1'b0;
         div_launch_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         obs_ff        <= obs_in;
         margin_ff     <= margin_in;
         smp_count_ff  <= smp_count_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         ovf_ff        <= ovf_in;
         rd_valid_ff   <= rd_valid_in;
         div_launch_ff <= div_launch_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      prod_lo_ff    <= prod_lo_in;
      prod_hi_ff    <= prod_hi_in;
      margin_lo_ff  <= margin_lo_in;
      margin_hi_ff  <= margin_hi_in;
      low_ff        <= low_in;
      high_ff       <= high_in;
      rd_idx_ff     <= rd_idx_in;
      first_ff      <= first_in;
      up_ff         <= up_in;
      cross_ff      <= cross_in;
      period_ff     <= period_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_low_ff    <= rsp_low_in;
      rsp_high_ff   <= rsp_high_in;
      rsp_cross_ff  <= rsp_cross_in;
      rsp_period_ff <= rsp_period_in;
      rsp_flags_ff  <= rsp_flags_in;
   end

   assign req_tready = state_ff == ST_LOAD;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = OUT_W'({rsp_period_ff, rsp_cross_ff, rsp_high_ff, rsp_low_ff,
                               rsp_max_ff, rsp_min_ff});
   assign rsp_tuser  = {rsp_flags_ff.store_overflow, rsp_flags_ff.no_crossings};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      smp_count_ff <= SCNT_W'(MAX_SAMPLES))
      else $error("sample count beyond store depth");

   a_walk_cross: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> 32'(cross_ff) <= 32'(smp_count_ff))
      else $error("more crossings than stored samples");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_P)
      else $error("divider finished outside the period division");

   a_no_cross: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> rsp_flags_ff.no_crossings == (rsp_cross_ff == '0))
      else $error("no_crossings disagrees with count");

   a_period_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_flags_ff.no_crossings |-> rsp_period_ff == '0)
      else $error("nonzero period without crossings");

endmodule

[tb/signal_range_period_calibrator_tb.sv]
`timescale 1ns / 100ps

import srpc_pkg::*;

localparam int SMP_W        = 16;
localparam int RECORD_DEPTH = 4096;
localparam int REQ_W        = ((SMP_W + 7) / 8) * 8;
localparam int RSP_W        = ((4 * SMP_W + CNT_W + PERIOD_W + 7) / 8) * 8;
localparam longint SMP_MAX  = 32767;
localparam longint SMP_MIN  = -32768;
localparam int MAX_REPORTS  = 200;

typedef struct {
   logic signed [SMP_W-1:0] min_level;
   logic signed [SMP_W-1:0] max_level;
   logic signed [SMP_W-1:0] low_threshold;
   logic signed [SMP_W-1:0] high_threshold;
   logic [CNT_W-1:0]        crossing_count;
   logic [PERIOD_W-1:0]     period_q16;
   logic                    no_crossings;
   logic                    store_overflow;
} calibration_t;

class calibrator_scoreboard;
   logic signed [SMP_W-1:0] record_mem [0:RECORD_DEPTH-1];
   int unsigned             n_stored;
   longint                  lo_level;
   longint                  hi_level;
   bit                      overflow;
   longint                  window_s;
   longint                  margin_pm;
   calibration_t            pending_calibrations [$];
   int unsigned             errors;
   int unsigned             results_seen;

   function new();
      window_s  = OBS_RESET;
      margin_pm = MARGIN_RESET;
      errors    = 0;
      results_seen = 0;
      clear_record();
   endfunction

   function void clear_record();
      n_stored = 0;
      lo_level = SMP_MAX;
      hi_level = SMP_MIN;
      overflow = 1'b0;
   endfunction

   function int pending();
      return pending_calibrations.size();
   endfunction

   function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      if (idx == CSR_OBSERVE_SECONDS)
         window_s = value[OBS_W-1:0];
      else if (idx == CSR_MARGIN_PERMILLE)
         margin_pm = value[MARGIN_W-1:0];
   endfunction

   function longint inward_margin(longint level);
      longint mag;
      mag = (level < 0) ? -level : level;
      return (mag * margin_pm) / PERMILLE_DIV;
   endfunction

   function longint saturate(longint v);
      if (v > SMP_MAX) return SMP_MAX;
      if (v < SMP_MIN) return SMP_MIN;
      return v;
   endfunction

   function void take_sample(logic signed [SMP_W-1:0] s, logic is_last);
      calibration_t r;
      longint       lo_thr;
      longint       hi_thr;
      longint       cnt;
      longint       period;
      bit           above;
      if (n_stored < RECORD_DEPTH) begin
         record_mem[n_stored] = s;
         n_stored++;
      end else begin
         overflow = 1'b1;
      end
      if (s < lo_level) lo_level = s;
      if (s > hi_level) hi_level = s;
      if (!is_last) return;

      lo_thr = saturate(lo_level + inward_margin(lo_level));
      hi_thr = saturate(hi_level - inward_margin(hi_level));
      cnt    = 0;
      period = 0;
      // a record that opens above the high threshold starts armed-high, not counted
      above  = (n_stored > 0) && (record_mem[0] > hi_thr);
      for (int unsigned i = 0; i < n_stored; i++) begin
         if (!above && record_mem[i] > hi_thr) begin
            cnt++;
            above = 1'b1;
         end else if (above && record_mem[i] < lo_thr) begin
            above = 1'b0;
         end
      end
      if (cnt != 0)
         period = (window_s << FRAC_BITS) / cnt;

      r.min_level      = SMP_W'(lo_level);
      r.max_level      = SMP_W'(hi_level);
      r.low_threshold  = SMP_W'(lo_thr);
      r.high_threshold = SMP_W'(hi_thr);
      r.crossing_count = CNT_W'(cnt);
      r.period_q16     = PERIOD_W'(period);
      r.no_crossings   = (cnt == 0);
      r.store_overflow = overflow;
      pending_calibrations.push_back(r);
      clear_record();
   endfunction

   task report(string field, longint got, longint want);
      if (errors < MAX_REPORTS)
         $display("%0t: result %0d, %s mismatch: got %0d, expected %0d",
                  $time, results_seen, field, got, want);
      errors++;
   endtask

   task check_calibration(logic [RSP_W-1:0] data, logic [1:0] flags);
      calibration_t got;
      calibration_t want;
      got.min_level      = data[0 +: SMP_W];
      got.max_level      = data[SMP_W +: SMP_W];
      got.low_threshold  = data[2*SMP_W +: SMP_W];
      got.high_threshold = data[3*SMP_W +: SMP_W];
      got.crossing_count = data[4*SMP_W +: CNT_W];
      got.period_q16     = data[4*SMP_W+CNT_W +: PERIOD_W];
      got.no_crossings   = flags[0];
      got.store_overflow = flags[1];
      results_seen++;
      if (pending_calibrations.size() == 0) begin
         report("unexpected transaction", got.crossing_count, 0);
         return;
      end
      want = pending_calibrations.pop_front();
      if (got.min_level !== want.min_level)
         report("min_level", got.min_level, want.min_level);
      if (got.max_level !== want.max_level)
         report("max_level", got.max_level, want.max_level);
      if (got.low_threshold !== want.low_threshold)
         report("low_threshold", got.low_threshold, want.low_threshold);
      if (got.high_threshold !== want.high_threshold)
         report("high_threshold", got.high_threshold, want.high_threshold);
      if (got.crossing_count !== want.crossing_count)
         report("crossing_count", got.crossing_count, want.crossing_count);
      if (got.period_q16 !== want.period_q16)
         report("period_q16", got.period_q16, want.period_q16);
      if (got.no_crossings !== want.no_crossings)
         report("no_crossings", got.no_crossings, want.no_crossings);
      if (got.store_overflow !== want.store_overflow)
         report("store_overflow", got.store_overflow, want.store_overflow);
   endtask
endclass

module signal_range_period_calibrator_tb;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = '1;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD      = 3000;
   localparam int CFG_SETTLE     = 100;
   localparam int DRAIN_CYCLES   = 300;
   localparam int PHASE_ITEMS    = 440;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_W-1:0]       rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   calibrator_scoreboard calib;
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int unsigned hold_requests;
   int unsigned hold_served;
   int unsigned samples_sent;
   int unsigned quiet_cycles;

   signal_range_period_calibrator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            calib.check_calibration(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready)
            calib.take_sample(req_tdata[SMP_W-1:0], req_tlast);
         if (csr_valid && csr_ready)
            calib.write_reg(csr_index, csr_data);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)
             || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      hold_served = 0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served++;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic logic signed [SMP_W-1:0] to_sample(int v);
      if (v > SMP_MAX) return SMP_W'(SMP_MAX);
      if (v < SMP_MIN) return SMP_W'(SMP_MIN);
      return SMP_W'(v);
   endfunction

   // called and returns at a falling edge; tvalid stays up for a following transaction
   task automatic send_sample(input logic signed [SMP_W-1:0] s, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(s);
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic send_record(input int unsigned length);
      int unsigned shape;
      int unsigned period_len;
      int unsigned amp;
      int unsigned noise;
      int          center;
      int          v;
      shape      = $urandom_range(9);
      period_len = $urandom_range(16, 2);
      amp        = $urandom_range(32767, 1);
      noise      = $urandom_range(amp / 3);
      center     = int'($urandom_range(40000)) - 20000;
      for (int unsigned i = 0; i < length; i++) begin
         if (shape < 7)
            v = center + (((i % period_len) < period_len / 2) ? int'(amp) : -int'(amp))
                + int'($urandom_range(2 * noise)) - int'(noise);
         else if (shape < 9)
            v = int'($signed(16'($urandom)));
         else
            v = ($urandom_range(1) != 0) ? 32767 : -32768;
         send_sample(to_sample(v), i == length - 1);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // only between records, once every calibration has come back
   task automatic configure(input logic [OBS_W-1:0] obs, input logic [MARGIN_W-1:0] margin,
                            input bit with_spare);
      req_tvalid <= 1'b0;
      while (calib.pending() != 0) @(negedge clock);
      repeat (CFG_SETTLE) @(negedge clock);
      if (with_spare) begin
         write_csr(CSR_SPARE_LOW, '1);
         write_csr(CSR_SPARE_HIGH, CSR_DATA_W'($urandom));
      end
      write_csr(CSR_OBSERVE_SECONDS, {(CSR_DATA_W - OBS_W)'($urandom), obs});
      write_csr(CSR_MARGIN_PERMILLE, margin);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned phase_start;
      calib = new();
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_requests = 0;
      samples_sent  = 0;
      quiet_cycles  = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset register values
      send_sample(to_sample(0), 1'b0);
      send_sample(to_sample(32767), 1'b0);
      send_sample(to_sample(-32768), 1'b0);
      send_sample(to_sample(32767), 1'b0);
      send_sample(to_sample(-32768), 1'b0);
      send_sample(16'sh5555, 1'b1);
      send_sample(to_sample(-32768), 1'b1);      // one-sample record
      send_sample(to_sample(30000), 1'b0);       // opens above the high threshold
      send_sample(to_sample(0), 1'b0);
      send_sample(to_sample(-30000), 1'b0);
      send_sample(to_sample(30000), 1'b1);
      send_sample(16'sh2AAA, 1'b0);              // flat: no crossings
      send_sample(16'sh2AAA, 1'b1);

      configure(OBS_W'(0), MARGIN_W'(511), 1'b1); // zero window, widest margin
      send_sample(to_sample(-100), 1'b0);
      send_sample(to_sample(32767), 1'b0);
      send_sample(to_sample(-100), 1'b0);
      send_sample(to_sample(32767), 1'b1);
      send_sample(to_sample(32767), 1'b0);       // low threshold saturates high
      send_sample(to_sample(32767), 1'b1);
      send_sample(to_sample(-32000), 1'b0);      // high threshold saturates low
      send_sample(to_sample(-32768), 1'b1);

      configure(OBS_W'(63), MARGIN_W'(0), 1'b0);
      send_sample(to_sample(5), 1'b0);
      send_sample(to_sample(32767), 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
               configure(OBS_W'(60), MARGIN_W'(500), 1'b0);
            end
            1: begin
               send_idle_pct = 77;
               stall_pct = 0;
               configure(OBS_W'(1), MARGIN_W'($urandom_range(511)), 1'b0);
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 77;
               configure(OBS_W'($urandom_range(63, 1)), MARGIN_W'($urandom_range(499, 1)),
                         1'b0);
            end
            default: begin
               send_idle_pct = 6;
               stall_pct = 6;
               configure(OBS_W'($urandom_range(63)), MARGIN_W'($urandom_range(511)), 1'b1);
            end
         endcase
         phase_start = samples_sent;
         if (phase == 0) begin
            // back-pressure: output held off while records keep arriving
            hold_requests++;
            repeat (6) send_record($urandom_range(24, 8));
         end
         while (samples_sent - phase_start < PHASE_ITEMS)
            send_record(($urandom_range(9) == 0) ? $urandom_range(400, 49)
                                                 : $urandom_range(48, 1));
      end

      req_tvalid <= 1'b0;
      while (calib.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (calib.errors == 0 && calib.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
